>>> rtl/core/sitrt_pkg.sv
// Shared types, codes and the microcode program of the radix text converter.
// No dependencies; imported by every module under rtl/core except sitrt_ram.
package sitrt_pkg;

    localparam int VALUE_W  = 64;
    localparam int RADIX_W  = 5;
    localparam int DIGIT_W  = 4;
    localparam int SYM_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int CFG_IDX_W = 2;

    // quotient bits retired per divider cycle
    localparam int DIV_BITS   = 8;
    localparam int DIV_SLICES = VALUE_W / DIV_BITS;
    localparam int SLICE_W    = $clog2(DIV_SLICES);

    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_TABLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNREPR    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET        = 5'd10;
    localparam logic [VALUE_W-1:0] SYMBOLS_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [VALUE_W-1:0] SYMBOLS_HIGH_RESET = 64'h0000_0000_0000_3938;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_CHECK,
        OP_NEGATE,
        OP_DIVIDE,
        OP_STORE,
        OP_SIGN,
        OP_DIGIT,
        OP_ERR_TABLE,
        OP_ERR_RANGE
    } op_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_CHECK_BUSY,
        C_TABLE_BAD,
        C_VALUE_MIN,
        C_DIGITS_FULL,
        C_DIV_BUSY,
        C_MAG_NZ,
        C_MORE_DIGITS
    } cond_t;

    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_WAIT      = 4'd0;
    localparam logic [PC_W-1:0] PC_CHECK     = 4'd1;
    localparam logic [PC_W-1:0] PC_VET       = 4'd2;
    localparam logic [PC_W-1:0] PC_RANGE     = 4'd3;
    localparam logic [PC_W-1:0] PC_FULL      = 4'd4;
    localparam logic [PC_W-1:0] PC_DIVIDE    = 4'd5;
    localparam logic [PC_W-1:0] PC_STORE     = 4'd6;
    localparam logic [PC_W-1:0] PC_SIGN      = 4'd7;
    localparam logic [PC_W-1:0] PC_READ      = 4'd8;
    localparam logic [PC_W-1:0] PC_EMIT      = 4'd9;
    localparam logic [PC_W-1:0] PC_DONE      = 4'd10;
    localparam logic [PC_W-1:0] PC_ERR_TABLE = 4'd11;
    localparam logic [PC_W-1:0] PC_ERR_RANGE = 4'd12;

    typedef struct packed {
        op_t             op;
        logic            hold;    // wait while the output register holds a result that is not taken
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic check_busy;
        logic table_bad;
        logic value_min;
        logic digits_full;
        logic div_busy;
        logic mag_nz;
        logic more_digits;
        logic out_full;
    } flags_t;

    typedef struct packed {
        op_t  op;
        logic fire;
    } ctrl_t;

    function automatic logic [SYM_W-1:0] sym_at(input logic [VALUE_W-1:0] lo,
                                                input logic [VALUE_W-1:0] hi,
                                                input logic [DIGIT_W-1:0] idx);
        logic [VALUE_W-1:0] w;
        w = idx[3] ? hi : lo;
        return w[{idx[2:0], 3'b000} +: SYM_W];
    endfunction

    function automatic uword_t mk(input op_t op, input logic hold, input cond_t cond,
                                  input logic [PC_W-1:0] target);
        uword_t w;
        w.op = op;
        w.hold = hold;
        w.cond = cond;
        w.target = target;
        return w;
    endfunction

    // control store: one word per step
    function automatic uword_t ucode_word(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            PC_WAIT:      w = mk(OP_LOAD,      1'b0, C_NO_INPUT,    PC_WAIT);
            PC_CHECK:     w = mk(OP_CHECK,     1'b0, C_CHECK_BUSY,  PC_CHECK);
            PC_VET:       w = mk(OP_NEGATE,    1'b0, C_TABLE_BAD,   PC_ERR_TABLE);
            PC_RANGE:     w = mk(OP_NOP,       1'b0, C_VALUE_MIN,   PC_ERR_RANGE);
            PC_FULL:      w = mk(OP_NOP,       1'b0, C_DIGITS_FULL, PC_ERR_RANGE);
            PC_DIVIDE:    w = mk(OP_DIVIDE,    1'b0, C_DIV_BUSY,    PC_DIVIDE);
            PC_STORE:     w = mk(OP_STORE,     1'b0, C_MAG_NZ,      PC_FULL);
            PC_SIGN:      w = mk(OP_SIGN,      1'b1, C_NEXT,        PC_WAIT);
            PC_READ:      w = mk(OP_NOP,       1'b0, C_NEXT,        PC_WAIT);
            PC_EMIT:      w = mk(OP_DIGIT,     1'b1, C_MORE_DIGITS, PC_READ);
            PC_DONE:      w = mk(OP_NOP,       1'b0, C_ALWAYS,      PC_WAIT);
            PC_ERR_TABLE: w = mk(OP_ERR_TABLE, 1'b1, C_ALWAYS,      PC_WAIT);
            PC_ERR_RANGE: w = mk(OP_ERR_RANGE, 1'b1, C_ALWAYS,      PC_WAIT);
            default:      w = mk(OP_NOP,       1'b0, C_ALWAYS,      PC_WAIT);
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/sitrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sitrt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/core/sitrt_chk.sv
// Symbol table checker: one symbol per cycle against sign marks and all later symbols.
// Depends on sitrt_pkg.
module sitrt_chk
    import sitrt_pkg::*;
#(
    parameter int MAX_RADIX = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               step,
    input  logic [RADIX_W-1:0] radix,
    input  logic [VALUE_W-1:0] sym_lo,
    input  logic [VALUE_W-1:0] sym_hi,
    output logic               busy,
    output logic               bad
);

    localparam int CHK_W = $clog2(MAX_RADIX);

    logic [CHK_W-1:0] idx_reg, idx_next;
    logic             bad_reg, bad_next;
    logic             hit;
    logic [SYM_W-1:0] cur;

    always_comb
    begin
        cur = sym_at(sym_lo, sym_hi, DIGIT_W'(idx_reg));
        hit = 1'b0;
        if (RADIX_W'(idx_reg) < radix)
        begin
            if (cur == SYM_MINUS || cur == SYM_PLUS)
            begin
                hit = 1'b1;
            end
            for (int j = 0; j < MAX_RADIX; j++)
            begin
                if (RADIX_W'(j) > RADIX_W'(idx_reg) && RADIX_W'(j) < radix &&
                    sym_at(sym_lo, sym_hi, DIGIT_W'(j)) == cur)
                begin
                    hit = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        bad_next = bad_reg;
        priority if (start)
        begin
            idx_next = '0;
            bad_next = 1'b0;
        end
        else if (step)
        begin
            idx_next = idx_reg + CHK_W'(1);
            bad_next = bad_reg | hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            bad_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            bad_reg <= bad_next;
        end
    end

    assign busy = idx_reg != CHK_W'(MAX_RADIX - 1);
    assign bad  = bad_reg || radix < MIN_RADIX || radix > RADIX_W'(MAX_RADIX);

    // a started check always begins clean
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (idx_reg == '0 && !bad_reg))
        else $error("checker did not restart");

endmodule

>>> rtl/core/sitrt_div.sv
// Radix divider: long division of the magnitude, several quotient bits per cycle.
// Depends on sitrt_pkg.
module sitrt_div
    import sitrt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [VALUE_W-1:0] load_mag,
    input  logic               step,
    input  logic [RADIX_W-1:0] radix,
    output logic [VALUE_W-1:0] mag,
    output logic [DIGIT_W-1:0] digit,
    output logic               busy
);

    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [SLICE_W-1:0] cnt_reg, cnt_next;
    logic [VALUE_W-1:0] q;
    logic [RADIX_W-1:0] r;

    // restoring division over one slice; quotient bits shift in at the bottom
    always_comb
    begin
        q = mag_reg;
        r = '0;
        if (cnt_reg != '0)
        begin
            r = RADIX_W'(rem_reg);
        end
        for (int b = 0; b < DIV_BITS; b++)
        begin
            r = {r[RADIX_W-2:0], q[VALUE_W-1]};
            q = {q[VALUE_W-2:0], 1'b0};
            if (r >= radix)
            begin
                r = r - radix;
                q[0] = 1'b1;
            end
        end
    end

    always_comb
    begin
        mag_next = mag_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        priority if (load)
        begin
            mag_next = load_mag;
            cnt_next = '0;
        end
        else if (step)
        begin
            mag_next = q;
            rem_next = r[DIGIT_W-1:0];
            cnt_next = (cnt_reg == SLICE_W'(DIV_SLICES - 1)) ? '0 : cnt_reg + SLICE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            mag_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            mag_reg <= mag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign mag   = mag_reg;
    assign digit = rem_reg;
    assign busy  = cnt_reg != SLICE_W'(DIV_SLICES - 1);

    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !load && radix >= MIN_RADIX) |=> (RADIX_W'(rem_reg) < $past(radix)))
        else $error("remainder not below radix");

endmodule

>>> rtl/core/sitrt_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on sitrt_pkg.
module sitrt_seq
    import sitrt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output ctrl_t  ctrl
);

    logic [PC_W-1:0] pc_reg, pc_next;
    uword_t          uw;
    logic            taken;
    logic            stall;

    assign uw    = ucode_word(pc_reg);
    assign stall = uw.hold && flags.out_full;

    always_comb
    begin
        unique case (uw.cond)
            C_NEXT:        taken = 1'b0;
            C_ALWAYS:      taken = 1'b1;
            C_NO_INPUT:    taken = !flags.in_valid;
            C_CHECK_BUSY:  taken = flags.check_busy;
            C_TABLE_BAD:   taken = flags.table_bad;
            C_VALUE_MIN:   taken = flags.value_min;
            C_DIGITS_FULL: taken = flags.digits_full;
            C_DIV_BUSY:    taken = flags.div_busy;
            C_MAG_NZ:      taken = flags.mag_nz;
            C_MORE_DIGITS: taken = flags.more_digits;
            default:       taken = 1'b1;
        endcase
    end

    always_comb
    begin
        priority if (stall)
        begin
            pc_next = pc_reg;
        end
        else if (taken)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.op   = uw.op;
    assign ctrl.fire = !stall;

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PC_ERR_RANGE)
        else $error("step counter left the program");

    a_stall_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> pc_reg == $past(pc_reg))
        else $error("step advanced while output stalled");

endmodule

>>> rtl/core/signed_integer_to_radix_text.sv
// Top level of the signed integer to radix text converter: config, datapath, output.
// Depends on sitrt_pkg, sitrt_seq, sitrt_chk, sitrt_div and sitrt_ram.

// Each accepted value becomes a stream of characters: a '-' for negative values, then the
// digits most significant first, with last and char_count on the final one. An invalid
// symbol table or radix gives one status 1 result, the most negative value or a digit
// count above MAX_DIGITS one status 2 result. A microcode sequencer runs the job one
// value at a time: the checker tests the table one symbol at a time, the divider retires
// 8 quotient bits per cycle, and each digit character leaves through the digit RAM read
// port. The sequencer waits while the output side stalls. The block accepts the next
// value while the final character of the previous one still waits in the output
// register. Configuration is written through cfg_write, cfg_index and cfg_data.
module signed_integer_to_radix_text
    import sitrt_pkg::*;
#(
    parameter int MAX_RADIX  = 16,
    parameter int MAX_DIGITS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [VALUE_W-1:0]          cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [VALUE_W-1:0]   value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [SYM_W-1:0]            symbol,
    output logic                        last,
    output logic [STATUS_W-1:0]         status,
    output logic [COUNT_W-1:0]          char_count
);

    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

    logic [RADIX_W-1:0]  radix_reg;
    logic [VALUE_W-1:0]  sym_lo_reg, sym_hi_reg;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic                out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]    symbol_reg, symbol_next;
    logic                last_reg, last_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    flags_t              flags;
    ctrl_t               ctrl;
    logic                accept;
    logic                neg;
    logic [VALUE_W-1:0]  mag_in;
    logic                chk_busy, chk_bad;
    logic [VALUE_W-1:0]  div_mag;
    logic [DIGIT_W-1:0]  div_digit;
    logic                div_busy;
    logic                div_load, div_step;
    logic                wr_en;
    logic [DIGIT_W-1:0]  rd_digit;
    logic [COUNT_W-1:0]  total;

    assign in_ready = ctrl.op == OP_LOAD;
    assign accept   = in_valid && in_ready;
    assign neg      = value_reg[VALUE_W-1];
    assign mag_in   = neg ? (~value_reg + VALUE_W'(1)) : value_reg;
    assign total    = COUNT_W'(n_reg) + COUNT_W'(neg);
    assign div_load = ctrl.op == OP_NEGATE;
    assign div_step = ctrl.op == OP_DIVIDE;
    assign wr_en    = ctrl.op == OP_STORE;

    always_comb
    begin
        flags.in_valid    = in_valid;
        flags.check_busy  = chk_busy;
        flags.table_bad   = chk_bad;
        flags.value_min   = value_reg == {1'b1, {(VALUE_W - 1){1'b0}}};
        flags.digits_full = n_reg == CNT_W'(MAX_DIGITS);
        flags.div_busy    = div_busy;
        flags.mag_nz      = div_mag != '0;
        flags.more_digits = ptr_reg != '0;
        flags.out_full    = out_valid_reg && !out_ready;
    end

    sitrt_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    sitrt_chk #(
        .MAX_RADIX (MAX_RADIX)
    ) u_chk (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .step   (ctrl.op == OP_CHECK),
        .radix  (radix_reg),
        .sym_lo (sym_lo_reg),
        .sym_hi (sym_hi_reg),
        .busy   (chk_busy),
        .bad    (chk_bad)
    );

    sitrt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .load_mag (mag_in),
        .step     (div_step),
        .radix    (radix_reg),
        .mag      (div_mag),
        .digit    (div_digit),
        .busy     (div_busy)
    );

    sitrt_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (n_reg[ADDR_W-1:0]),
        .wr_data (div_digit),
        .rd_addr (ptr_reg),
        .rd_data (rd_digit)
    );

    always_comb
    begin
        value_next     = value_reg;
        n_next         = n_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        if (accept)
        begin
            value_next = value;
        end
        if (ctrl.fire)
        begin
            unique case (ctrl.op)
                OP_NEGATE:
                begin
                    n_next = '0;
                end
                OP_STORE:
                begin
                    n_next = n_reg + CNT_W'(1);
                end
                OP_SIGN:
                begin
                    ptr_next = ADDR_W'(n_reg - CNT_W'(1));
                    if (neg)
                    begin
                        out_valid_next = 1'b1;
                        symbol_next    = SYM_MINUS;
                        last_next      = 1'b0;
                        status_next    = ST_OK;
                        count_next     = '0;
                    end
                end
                OP_DIGIT:
                begin
                    ptr_next       = ptr_reg - ADDR_W'(1);
                    out_valid_next = 1'b1;
                    symbol_next    = sym_at(sym_lo_reg, sym_hi_reg, rd_digit);
                    last_next      = ptr_reg == '0;
                    status_next    = ST_OK;
                    count_next     = (ptr_reg == '0) ? total : '0;
                end
                OP_ERR_TABLE, OP_ERR_RANGE:
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = '0;
                    last_next      = 1'b1;
                    status_next    = (ctrl.op == OP_ERR_TABLE) ? ST_BAD_TABLE : ST_UNREPR;
                    count_next     = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= RADIX_RESET;
            sym_lo_reg    <= SYMBOLS_LOW_RESET;
            sym_hi_reg    <= SYMBOLS_HIGH_RESET;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_RADIX:        radix_reg  <= cfg_data[RADIX_W-1:0];
                    CFG_SYMBOLS_LOW:  sym_lo_reg <= cfg_data;
                    CFG_SYMBOLS_HIGH: sym_hi_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        ptr_reg    <= ptr_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        count_reg  <= count_next;
    end

    assign out_valid  = out_valid_reg;
    assign symbol     = symbol_reg;
    assign last       = last_reg;
    assign status     = status_reg;
    assign char_count = count_reg;

    a_error_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (last && char_count == '0 && symbol == '0))
        else $error("error transaction not a lone last result");

    a_one_value_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second value taken while converting");

    a_digit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond store depth");

endmodule
